// ===== rtl/core/scal_pkg.sv =====
// ----------------------------------------------------------------------------
// scal_pkg
// Shared types and constants of the sound channel allocator: channel table
// entry, request and result words, opcode and status codes.
// ----------------------------------------------------------------------------
package scal_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int SOUND_BITS   = 9;
    localparam int SOURCE_BITS  = 16;

    // Channel index and channel count widths
    localparam int CHAN_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int COUNT_W = $clog2(MAX_CHANNELS + 1);

    // Fixed field widths
    localparam int OP_W     = 3;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int GRANT_W  = 3;
    localparam int ACTIVE_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Opcodes
    localparam logic [OP_W-1:0] OP_START      = 3'd0;
    localparam logic [OP_W-1:0] OP_START_ONCE = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP       = 3'd2;
    localparam logic [OP_W-1:0] OP_DETACH     = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_GRANTED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CHANNELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_SOURCE = 2'd1;

    localparam logic [SOURCE_BITS-1:0] SOURCE_NONE     = '0;
    localparam logic [SOURCE_BITS-1:0] SOURCE_DETACHED = '1;

    typedef struct packed {
        logic [OP_W-1:0]        opcode;
        logic [SOUND_BITS-1:0]  sound_id;
        logic [SOURCE_BITS-1:0] source_id;
        logic [PRIO_W-1:0]      request_priority;
        logic [GRANT_W-1:0]     channel_index;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GRANT_W-1:0]  granted_channel;
    } result_t;

    typedef struct packed {
        logic                   busy;
        logic [SOUND_BITS-1:0]  sound;
        logic [SOURCE_BITS-1:0] source;
        logic [PRIO_W-1:0]      prio;
    } chan_entry_t;

endpackage

// ===== rtl/core/scal_chan_table.sv =====
// ----------------------------------------------------------------------------
// scal_chan_table
// Channel table memory: one write port, one read port with registered data.
// Per-entry valid bits make an unwritten entry read as all zero.
// ----------------------------------------------------------------------------
module scal_chan_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [scal_pkg::CHAN_W-1:0]      wr_addr,
    input  scal_pkg::chan_entry_t            wr_entry,
    input  logic [scal_pkg::CHAN_W-1:0]      rd_addr,
    output scal_pkg::chan_entry_t            rd_entry
);
    import scal_pkg::*;

    chan_entry_t               mem [MAX_CHANNELS];
    chan_entry_t               rd_data_reg;
    logic [MAX_CHANNELS-1:0]   vld_reg;
    logic                      rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // Never-written entries read as zero through their clear valid bit
    assign rd_entry = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/core/sound_channel_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// sound_channel_allocator_unit
// Sound channel allocator with priority steal, built around a channel table
// memory that is scanned one entry per cycle.
// ----------------------------------------------------------------------------
// Pulse start for one cycle with a request word while busy is low; the word is
// taken at that edge. Exactly one result word follows on result, marked by a
// one-cycle done strobe; it cannot be held off, so capture it when done is
// high. With n the active channel count (1..8), a start or start-once makes
// a read pass over the n active channels and then a grant step that picks
// and writes the channel, a detach or clear makes the read pass alone, a stop
// reads and frees just its own channel, and a stop out of range or an unknown
// opcode reports at once. The channel table serves one read per cycle, so the
// scan visits one channel each cycle. Start may be raised again
// in the cycle in which done shows the previous result. Write configuration
// registers only while the block is idle (busy low and the last result
// delivered); cfg_ready is always high. An active_channels value of 0 acts as
// 1 and a value above 8 acts as 8; channels above the active count keep their
// contents and are never visited.
// ----------------------------------------------------------------------------
module sound_channel_allocator_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  scal_pkg::request_t               request,
    output logic                             done,
    output scal_pkg::result_t                result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [scal_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scal_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import scal_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_GRANT
    } state_t;

    state_t                  state_reg;
    request_t                req_reg;
    logic [COUNT_W-1:0]      n_reg;
    logic [CHAN_W-1:0]       ev_reg;
    logic [CHAN_W-1:0]       last_reg;
    logic [CHAN_W-1:0]       ptr_reg;
    logic                    done_reg;
    result_t                 result_reg;

    logic [ACTIVE_W-1:0]     active_channels_reg;
    logic [SOURCE_BITS-1:0]  listener_source_reg;

    // First-match trackers of the four steal scans, plus the duplicate flag
    logic                    free_found_reg, nosrc_found_reg;
    logic                    lis_found_reg, prio_found_reg;
    logic [CHAN_W-1:0]       free_idx_reg, nosrc_idx_reg;
    logic [CHAN_W-1:0]       lis_idx_reg, prio_idx_reg;
    logic                    dup_reg;

    // Table port signals
    logic                    wr_en;
    logic [CHAN_W-1:0]       wr_addr;
    chan_entry_t             wr_entry;
    logic [CHAN_W-1:0]       rd_addr;
    chan_entry_t             rd_entry;

    // Decoded values
    logic [COUNT_W-1:0]      n_in;
    logic                    is_start_in;
    logic                    stop_ok;
    logic                    scan_in;
    logic                    is_start;
    logic                    last_ev;
    logic [CHAN_W-1:0]       ptr_sel;
    logic [CHAN_W-1:0]       pick;
    logic [COUNT_W-1:0]      pick_inc;

    scal_chan_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    // Clamp the configured channel count into 1..MAX_CHANNELS
    always_comb
    begin
        if (active_channels_reg == '0)
        begin
            n_in = COUNT_W'(1);
        end
        else if (ACTIVE_W'(active_channels_reg) > ACTIVE_W'(MAX_CHANNELS))
        begin
            n_in = COUNT_W'(MAX_CHANNELS);
        end
        else
        begin
            n_in = COUNT_W'(active_channels_reg);
        end
    end

    assign is_start_in = (request.opcode == OP_START) || (request.opcode == OP_START_ONCE);
    assign stop_ok     = (COUNT_W'(request.channel_index) < n_in);
    assign scan_in     = is_start_in || (request.opcode == OP_DETACH)
                      || (request.opcode == OP_CLEAR)
                      || ((request.opcode == OP_STOP) && stop_ok);
    assign is_start    = (req_reg.opcode == OP_START) || (req_reg.opcode == OP_START_ONCE);
    assign last_ev     = (ev_reg == last_reg);

    // Read the first channel of the pass at accept, then the next each cycle
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            rd_addr = (request.opcode == OP_STOP) ? CHAN_W'(request.channel_index) : '0;
        end
        else
        begin
            rd_addr = ev_reg + CHAN_W'(1);
        end
    end

    // Pick the channel: free, no source, listener, priority, then the pointer
    assign ptr_sel = (COUNT_W'(ptr_reg) < n_reg) ? ptr_reg : '0;

    always_comb
    begin
        priority if (free_found_reg)
        begin
            pick = free_idx_reg;
        end
        else if (nosrc_found_reg)
        begin
            pick = nosrc_idx_reg;
        end
        else if (lis_found_reg)
        begin
            pick = lis_idx_reg;
        end
        else if (prio_found_reg)
        begin
            pick = prio_idx_reg;
        end
        else
        begin
            pick = ptr_sel;
        end
    end

    assign pick_inc = COUNT_W'(pick) + COUNT_W'(1);

    // Write back: modify entries during the pass, fill the picked channel after unless a duplicate
    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = ev_reg;
        wr_entry = rd_entry;
        unique case (state_reg)
            S_SCAN:
            begin
                if (req_reg.opcode == OP_STOP)
                begin
                    wr_en         = 1'b1;
                    wr_entry.busy = 1'b0;
                end
                else if (req_reg.opcode == OP_DETACH)
                begin
                    wr_en = (req_reg.source_id != SOURCE_NONE) && rd_entry.busy
                         && (rd_entry.source == req_reg.source_id);
                    wr_entry.source = SOURCE_DETACHED;
                end
                else if (req_reg.opcode == OP_CLEAR)
                begin
                    wr_en           = 1'b1;
                    wr_entry.source = SOURCE_NONE;
                end
            end
            S_GRANT:
            begin
                wr_en           = !dup_reg;
                wr_addr         = pick;
                wr_entry.busy   = 1'b1;
                wr_entry.sound  = req_reg.sound_id;
                wr_entry.source = req_reg.source_id;
                wr_entry.prio   = req_reg.request_priority;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Sequencer: accept, scan the table, then grant and report
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            req_reg         <= '0;
            n_reg           <= COUNT_W'(1);
            ev_reg          <= '0;
            last_reg        <= '0;
            ptr_reg         <= '0;
            done_reg        <= 1'b0;
            result_reg      <= '0;
            free_found_reg  <= 1'b0;
            nosrc_found_reg <= 1'b0;
            lis_found_reg   <= 1'b0;
            prio_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            nosrc_idx_reg   <= '0;
            lis_idx_reg     <= '0;
            prio_idx_reg    <= '0;
            dup_reg         <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg         <= request;
                        n_reg           <= n_in;
                        free_found_reg  <= 1'b0;
                        nosrc_found_reg <= 1'b0;
                        lis_found_reg   <= 1'b0;
                        prio_found_reg  <= 1'b0;
                        dup_reg         <= 1'b0;
                        if (scan_in)
                        begin
                            state_reg <= S_SCAN;
                            ev_reg    <= rd_addr;
                            last_reg  <= (request.opcode == OP_STOP)
                                       ? request.channel_index
                                       : CHAN_W'(n_in - COUNT_W'(1));
                        end
                        else
                        begin
                            // Stop out of range or unknown opcode: report at once
                            done_reg   <= 1'b1;
                            result_reg <= '{status: ST_DONE, granted_channel: '0};
                        end
                    end
                end
                S_SCAN:
                begin
                    if (is_start)
                    begin
                        if (!free_found_reg && !rd_entry.busy)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= ev_reg;
                        end
                        if (!nosrc_found_reg && (rd_entry.source == SOURCE_NONE))
                        begin
                            nosrc_found_reg <= 1'b1;
                            nosrc_idx_reg   <= ev_reg;
                        end
                        if (!lis_found_reg && (rd_entry.source == listener_source_reg))
                        begin
                            lis_found_reg <= 1'b1;
                            lis_idx_reg   <= ev_reg;
                        end
                        if (!prio_found_reg && (rd_entry.prio >= req_reg.request_priority))
                        begin
                            prio_found_reg <= 1'b1;
                            prio_idx_reg   <= ev_reg;
                        end
                        if ((req_reg.opcode == OP_START_ONCE) && rd_entry.busy
                            && (rd_entry.sound == req_reg.sound_id)
                            && (rd_entry.source == req_reg.source_id))
                        begin
                            dup_reg <= 1'b1;
                        end
                    end
                    ev_reg <= rd_addr;
                    if (last_ev)
                    begin
                        if (is_start)
                        begin
                            state_reg <= S_GRANT;
                        end
                        else
                        begin
                            state_reg  <= S_IDLE;
                            done_reg   <= 1'b1;
                            result_reg <= '{status: ST_DONE, granted_channel: '0};
                        end
                    end
                end
                S_GRANT:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                    if (dup_reg)
                    begin
                        result_reg <= '{status: ST_DUPLICATE, granted_channel: '0};
                    end
                    else
                    begin
                        // Advance the pointer past the picked channel, wrap at n
                        ptr_reg    <= (pick_inc >= n_reg) ? '0 : CHAN_W'(pick_inc);
                        result_reg <= '{status: ST_GRANTED,
                                        granted_channel: GRANT_W'(pick)};
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_channels_reg <= ACTIVE_W'(MAX_CHANNELS);
            listener_source_reg <= SOURCE_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_ACTIVE_CHANNELS)
            begin
                active_channels_reg <= cfg_data[ACTIVE_W-1:0];
            end
            else if (cfg_index == CFG_LISTENER_SOURCE)
            begin
                listener_source_reg <= cfg_data[SOURCE_BITS-1:0];
            end
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    // A result word never shows while an operation is still in flight
    a_no_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result strobe while busy");

    // A granted channel lies inside the active range
    a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_GRANTED))
            |-> (COUNT_W'(result.granted_channel) < n_reg))
        else $error("granted channel outside active range");

    // Results other than a grant carry channel zero
    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_GRANTED)) |-> (result.granted_channel == '0))
        else $error("non-grant result carries a channel");

    // A start request always walks the table before it reports
    a_start_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && is_start_in) |=> (busy && !done))
        else $error("start request reported without a scan");

    // The pass ends with the grant step exactly for start requests
    a_grant_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GRANT) |-> ($past(state_reg) == S_SCAN) && is_start)
        else $error("grant step outside a start request");

endmodule
